// ===== sv/lfu_pkg.sv =====
// lfu_pkg: shared types and constants for the lfu cache
// no dependencies; imported by lfu_cache and tb_top
`default_nettype none

package lfu_pkg;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = 5;
  localparam int STAMP_W = 48;

  // request codes; code 3 is unused and does nothing
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_POP = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== sv/lfu_cache.sv =====
// lfu_cache: fully associative key/value store with lfu replacement
// depends on lfu_pkg and lfu_store
`default_nettype none

// Usage:
//   Requests enter on the in_ channel (valid/ready): command put, get or pop
//   with key and value. Each request gives exactly one result on the out_
//   channel: hit, read value on a get hit, evicted flag and occupancy after
//   the request. Capacity is written through cfg_wr_en/cfg_wr_data; the user
//   must write it only while idle, as the block does not enforce this.
//   Timing: one request at a time. Each request makes one scan of the entry
//   memory, one read per cycle through its single read port, plus a decide
//   and a result step. A put miss at capacity returns to the decide state
//   for the eviction; one that must evict more than one entry (capacity
//   lowered below occupancy) rescans once per extra victim.
//   The scan tracks key match, lowest (count, stamp) victim and lowest free
//   slot; the decide cycle does the single write back.
//   Reset (rst_n low, synchronous) clears valid bits, occupancy, the sequence
//   counter and sets capacity to ENTRIES; memory contents are not cleared.
//   When out_ready is low the result waits in the output register; the next
//   request is still taken and runs, and its result waits until the register
//   is free.

module lfu_cache #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [lfu_pkg::CAP_W-1:0]     cfg_wr_data,
  // requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lfu_pkg::CMD_W-1:0]     in_command,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [VALUE_BITS-1:0]              out_read_value,
  output logic                               out_evicted,
  output logic [lfu_pkg::OCC_W-1:0]          out_occupancy
);

  import lfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = KEY_BITS + VALUE_BITS + COUNT_BITS + STAMP_W;
  // word layout: key | value | count | stamp
  localparam int STAMP_LO = 0;
  localparam int COUNT_LO = STAMP_W;
  localparam int VALUE_LO = STAMP_W + COUNT_BITS;
  localparam int KEY_LO   = STAMP_W + COUNT_BITS + VALUE_BITS;

  // control state
  state_t                  state_r, state_nxt;
  logic [ENTRIES-1:0]      valid_r, valid_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic [STAMP_W-1:0]      seq_r, seq_nxt;
  logic [CAP_W-1:0]        cap_r;

  // request registers
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;

  // scan pipeline
  logic [IDX_W-1:0]        issue_idx_r, issue_idx_nxt;
  logic                    issue_done_r, issue_done_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        data_idx_r, data_idx_nxt;

  // scan trackers
  logic                    match_found_r, match_found_nxt;
  logic [IDX_W-1:0]        match_idx_r, match_idx_nxt;
  logic [VALUE_BITS-1:0]   match_val_r, match_val_nxt;
  logic [COUNT_BITS-1:0]   match_cnt_r, match_cnt_nxt;
  logic                    min_found_r, min_found_nxt;
  logic [IDX_W-1:0]        min_idx_r, min_idx_nxt;
  logic [COUNT_BITS-1:0]   min_cnt_r, min_cnt_nxt;
  logic [STAMP_W-1:0]      min_stamp_r, min_stamp_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IDX_W-1:0]        free_idx_r, free_idx_nxt;

  // pending result
  logic                    res_hit_r, res_hit_nxt;
  logic [VALUE_BITS-1:0]   res_val_r, res_val_nxt;
  logic                    res_ev_r, res_ev_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [VALUE_BITS-1:0]   out_val_r, out_val_nxt;
  logic                    out_ev_r, out_ev_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  // memory ports
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic                    rd_en;
  logic [WORD_W-1:0]       rd_data;

  // fields of the word read back
  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_val;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic [STAMP_W-1:0]      rd_stamp;
  logic                    rd_valid;

  // capacity clamped to 1..ENTRIES, and occupancy at the same width
  logic [CMP_W-1:0]        cap_eff;
  logic [CMP_W-1:0]        occ_ext;
  logic [COUNT_BITS-1:0]   cnt_bumped;

  lfu_store #(
    .ENTRIES (ENTRIES),
    .WIDTH   (WORD_W),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_idx_r),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[KEY_LO +: KEY_BITS];
  assign rd_val   = rd_data[VALUE_LO +: VALUE_BITS];
  assign rd_cnt   = rd_data[COUNT_LO +: COUNT_BITS];
  assign rd_stamp = rd_data[STAMP_LO +: STAMP_W];
  assign rd_valid = valid_r[data_idx_r];

  // effective capacity
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign occ_ext    = CMP_W'(occ_r);
  assign cnt_bumped = (match_cnt_r == '1) ? match_cnt_r : match_cnt_r + COUNT_BITS'(1);

  // next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    occ_nxt         = occ_r;
    seq_nxt         = seq_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    val_nxt         = val_r;
    issue_idx_nxt   = issue_idx_r;
    issue_done_nxt  = issue_done_r;
    pend_nxt        = 1'b0;
    data_idx_nxt    = data_idx_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    match_val_nxt   = match_val_r;
    match_cnt_nxt   = match_cnt_r;
    min_found_nxt   = min_found_r;
    min_idx_nxt     = min_idx_r;
    min_cnt_nxt     = min_cnt_r;
    min_stamp_nxt   = min_stamp_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    res_hit_nxt     = res_hit_r;
    res_val_nxt     = res_val_r;
    res_ev_nxt      = res_ev_r;
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_val_nxt     = out_val_r;
    out_ev_nxt      = out_ev_r;
    out_occ_nxt     = out_occ_r;
    wr_en           = 1'b0;
    wr_addr         = match_idx_r;
    wr_data         = {key_r, val_r, cnt_bumped, seq_r};
    rd_en           = 1'b0;
    in_ready        = 1'b0;

    // result leaves on an output transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt         = in_command;
          key_nxt         = in_key;
          val_nxt         = in_value;
          res_hit_nxt     = 1'b0;
          res_val_nxt     = '0;
          res_ev_nxt      = 1'b0;
          issue_idx_nxt   = '0;
          issue_done_nxt  = 1'b0;
          match_found_nxt = 1'b0;
          min_found_nxt   = 1'b0;
          free_found_nxt  = 1'b0;
          if (in_command == CMD_PUT || in_command == CMD_GET || in_command == CMD_POP) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle
        if (!issue_done_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          data_idx_nxt = issue_idx_r;
          if (issue_idx_r == IDX_W'(ENTRIES - 1)) begin
            issue_done_nxt = 1'b1;
          end else begin
            issue_idx_nxt = issue_idx_r + IDX_W'(1);
          end
        end
        // examine the word read last cycle
        if (pend_r) begin
          if (rd_valid && rd_key == key_r && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = data_idx_r;
            match_val_nxt   = rd_val;
            match_cnt_nxt   = rd_cnt;
          end
          if (rd_valid && (!min_found_r || rd_cnt < min_cnt_r ||
              (rd_cnt == min_cnt_r && rd_stamp < min_stamp_r))) begin
            min_found_nxt = 1'b1;
            min_idx_nxt   = data_idx_r;
            min_cnt_nxt   = rd_cnt;
            min_stamp_nxt = rd_stamp;
          end
          if (!rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = data_idx_r;
          end
          if (issue_done_r) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_RESP;
        case (cmd_r)
          CMD_PUT: begin
            if (match_found_r) begin
              // hit: new value, bumped count, fresh stamp
              wr_en       = 1'b1;
              seq_nxt     = seq_r + STAMP_W'(1);
              res_hit_nxt = 1'b1;
            end else if (occ_ext >= cap_eff && min_found_r) begin
              // at capacity: drop the victim, then rescan or insert
              valid_nxt[min_idx_r] = 1'b0;
              occ_nxt              = occ_r - CNT_W'(1);
              res_ev_nxt           = 1'b1;
              if (!free_found_r || min_idx_r < free_idx_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = min_idx_r;
              end
              if (occ_ext > cap_eff) begin
                state_nxt       = ST_SCAN;
                issue_idx_nxt   = '0;
                issue_done_nxt  = 1'b0;
                min_found_nxt   = 1'b0;
                free_found_nxt  = 1'b0;
              end else begin
                state_nxt = ST_DECIDE;
              end
            end else if (free_found_r) begin
              // insert into the lowest free slot with count one
              wr_en                 = 1'b1;
              wr_addr               = free_idx_r;
              wr_data               = {key_r, val_r, COUNT_BITS'(1), seq_r};
              seq_nxt               = seq_r + STAMP_W'(1);
              valid_nxt[free_idx_r] = 1'b1;
              occ_nxt               = occ_r + CNT_W'(1);
            end
          end
          CMD_GET: begin
            if (match_found_r) begin
              wr_en       = 1'b1;
              wr_data     = {key_r, match_val_r, cnt_bumped, seq_r};
              seq_nxt     = seq_r + STAMP_W'(1);
              res_hit_nxt = 1'b1;
              res_val_nxt = match_val_r;
            end
          end
          CMD_POP: begin
            if (min_found_r) begin
              valid_nxt[min_idx_r] = 1'b0;
              occ_nxt              = occ_r - CNT_W'(1);
              res_ev_nxt           = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ST_RESP: begin
        // load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_val_nxt   = res_val_r;
          out_ev_nxt    = res_ev_r;
          out_occ_nxt   = OCC_W'(occ_ext);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      occ_r        <= '0;
      seq_r        <= '0;
      cap_r        <= CAP_W'(ENTRIES);
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      occ_r        <= occ_nxt;
      seq_r        <= seq_nxt;
      issue_done_r <= issue_done_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    val_r         <= val_nxt;
    issue_idx_r   <= issue_idx_nxt;
    data_idx_r    <= data_idx_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    match_val_r   <= match_val_nxt;
    match_cnt_r   <= match_cnt_nxt;
    min_found_r   <= min_found_nxt;
    min_idx_r     <= min_idx_nxt;
    min_cnt_r     <= min_cnt_nxt;
    min_stamp_r   <= min_stamp_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    res_hit_r     <= res_hit_nxt;
    res_val_r     <= res_val_nxt;
    res_ev_r      <= res_ev_nxt;
    out_hit_r     <= out_hit_nxt;
    out_val_r     <= out_val_nxt;
    out_ev_r      <= out_ev_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;
  assign out_evicted    = out_ev_r;
  assign out_occupancy  = out_occ_r;

endmodule

`default_nettype wire

// ===== sv/lfu_store.sv =====
// lfu_store: entry memory holding key, value, use count and stamp per slot
// one write port, one read port with a registered read
`default_nettype none

module lfu_store #(
  parameter int ENTRIES = 16,
  parameter int WIDTH   = 128,
  parameter int IDX_W   = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the lfu_cache key/value store
// depends on lfu_pkg and lfu_cache; predicts every result with its own lfu model
`default_nettype none

module tb_top;
  import lfu_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int POOL_SIZE  = 24;
  localparam int PHASE_REQS = 100;

  // unused request code, must leave the store untouched
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [OCC_W-1:0]      occupancy;
  } rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]      cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = '0;
  logic [KEY_BITS-1:0]   in_key = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [VALUE_BITS-1:0] out_read_value;
  logic                  out_evicted;
  logic [OCC_W-1:0]      out_occupancy;

  // predicted store contents
  logic                  ent_valid [ENTRIES];
  logic [KEY_BITS-1:0]   ent_key   [ENTRIES];
  logic [VALUE_BITS-1:0] ent_value [ENTRIES];
  logic [COUNT_BITS-1:0] ent_count [ENTRIES];
  logic [STAMP_W-1:0]    ent_stamp [ENTRIES];
  logic [STAMP_W-1:0]    seq_ctr;
  logic [CAP_W-1:0]      cap_reg;

  req_t                  request_q [$];
  rsp_t                  cache_answers [$];
  req_t                  on_bus;
  logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
  logic [CAP_W-1:0]      phase_caps [9] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd0, 5'd9,
                                            5'd0, 5'd16};
  int                    reqs_open = 0;
  int                    mismatch_cnt = 0;
  int                    send_gap = 0;
  int                    stall_left = 0;
  bit                    send_burst = 1'b0;
  bit                    recv_burst = 1'b0;

  lfu_cache #(
    .ENTRIES(ENTRIES),
    .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit(out_hit),
    .out_read_value(out_read_value),
    .out_evicted(out_evicted),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- lfu model

  function automatic int find_entry(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && ent_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int live_count();
    int n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i]) n++;
    return n;
  endfunction

  function automatic void stamp_entry(int i);
    ent_stamp[i] = seq_ctr;
    seq_ctr = seq_ctr + 1'b1;
  endfunction

  // count saturates but the stamp is always renewed
  function automatic void bump_entry(int i);
    if (ent_count[i] != '1) ent_count[i] = ent_count[i] + 1'b1;
    stamp_entry(i);
  endfunction

  // victim: lowest count, then oldest stamp
  function automatic bit evict_lfu();
    int best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!ent_valid[i]) continue;
      if (best < 0 || ent_count[i] < ent_count[best] ||
          (ent_count[i] == ent_count[best] && ent_stamp[i] < ent_stamp[best]))
        best = i;
    end
    if (best < 0) return 1'b0;
    ent_valid[best] = 1'b0;
    return 1'b1;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t res;
    int   idx;
    int   lim;
    res = '0;
    case (r.cmd)
      CMD_PUT: begin
        idx = find_entry(r.key);
        if (idx >= 0) begin
          bump_entry(idx);
          ent_value[idx] = r.value;
          res.hit = 1'b1;
        end else begin
          // capacity 0 acts as 1, above ENTRIES acts as ENTRIES
          lim = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
          while (live_count() >= lim && evict_lfu()) res.evicted = 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!ent_valid[i]) begin
              ent_valid[i] = 1'b1;
              ent_key[i]   = r.key;
              ent_value[i] = r.value;
              ent_count[i] = COUNT_BITS'(1);
              stamp_entry(i);
              break;
            end
          end
        end
      end
      CMD_GET: begin
        idx = find_entry(r.key);
        if (idx >= 0) begin
          bump_entry(idx);
          res.read_value = ent_value[idx];
          res.hit = 1'b1;
        end
      end
      CMD_POP: res.evicted = evict_lfu();
      default: ;
    endcase
    res.occupancy = OCC_W'(live_count());
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic void flag_error(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", what);
  endfunction

  // idle lengths: mostly short, a few long, none in burst stretches
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.cmd = (pick < 45) ? CMD_PUT : (pick < 85) ? CMD_GET : (pick < 96) ? CMD_POP : CMD_NOP;
    // pool keys give hits, fresh keys give misses
    r.key = ($urandom_range(0, 4) == 0) ? KEY_BITS'($urandom)
                                        : key_pool[$urandom_range(0, POOL_SIZE-1)];
    r.value = VALUE_BITS'($urandom);
    return r;
  endfunction

  task automatic add_request(logic [CMD_W-1:0] cmd, logic [KEY_BITS-1:0] key,
                             logic [VALUE_BITS-1:0] value);
    request_q.push_back('{cmd: cmd, key: key, value: value});
    reqs_open++;
  endtask

  // hold the sender until every predicted result has been seen
  task automatic wait_idle();
    while (reqs_open != 0 || cache_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    cap_reg = cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : driver
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      // request transfer: predict its result now
      if (in_valid && in_ready) begin
        cache_answers.push_back(cache_access(on_bus));
        reqs_open--;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          on_bus = request_q.pop_front();
          in_command <= on_bus.cmd;
          in_key     <= on_bus.key;
          in_value   <= on_bus.value;
          nxt_valid = 1'b1;
          send_gap = pick_gap(send_burst);
        end
      end
      in_valid <= nxt_valid;
      if ($urandom_range(0, 199) == 0) send_burst = !send_burst;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    rsp_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (cache_answers.size() == 0) begin
          flag_error($sformatf("unexpected result hit=%0b rd=%h ev=%0b occ=%0d",
                               out_hit, out_read_value, out_evicted, out_occupancy));
        end else begin
          want = cache_answers.pop_front();
          if (want.hit !== out_hit || want.read_value !== out_read_value ||
              want.evicted !== out_evicted || want.occupancy !== out_occupancy)
            flag_error($sformatf(
              "expected hit=%0b rd=%h ev=%0b occ=%0d, got hit=%0b rd=%h ev=%0b occ=%0d",
              want.hit, want.read_value, want.evicted, want.occupancy,
              out_hit, out_read_value, out_evicted, out_occupancy));
        end
      end
      // receiver stalls
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (!recv_burst && $urandom_range(0, 5) == 0) begin
          stall_left = pick_gap(1'b0);
          if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
          end
        end
      end
      out_ready <= nxt_ready;
      if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_count[i] = '0;
      ent_stamp[i] = '0;
    end
    seq_ctr = '0;
    cap_reg = CAP_W'(ENTRIES);
    foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    phase_caps[7] = CAP_W'($urandom_range(2, 15));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small capacity so eviction shows up early
    write_capacity(5'd4);
    add_request(CMD_POP, '0, '0);                // pop on empty store
    add_request(CMD_GET, '0, '0);                // get miss
    add_request(CMD_NOP, '1, '1);                // unused code
    add_request(CMD_PUT, '0, '0);
    add_request(CMD_PUT, '1, '1);
    add_request(CMD_GET, '1, '0);
    add_request(CMD_PUT, '0, 32'ha5a5_5a5a);     // put hit overwrites
    add_request(CMD_GET, '0, '1);
    add_request(CMD_PUT, 32'd1, 32'd1);
    add_request(CMD_PUT, 32'd2, 32'd2);
    add_request(CMD_PUT, 32'd3, 32'd3);          // miss at capacity, tie on count
    add_request(CMD_GET, 32'd1, '0);
    add_request(CMD_GET, 32'd2, '0);
    add_request(CMD_POP, '0, '0);
    add_request(CMD_NOP, 32'h5555_aaaa, 32'haaaa_5555);
    wait_idle();
    // capacity 0 below occupancy: nothing leaves until the next put miss
    write_capacity(5'd0);
    add_request(CMD_GET, '0, '0);
    add_request(CMD_PUT, 32'd7, 32'h1234_5678);
    add_request(CMD_PUT, 32'd8, 32'h8765_4321);
    add_request(CMD_GET, 32'd8, '0);
    wait_idle();
    write_capacity(5'd31);
    for (int i = 0; i < 4; i++) add_request(CMD_PUT, key_pool[i], VALUE_BITS'($urandom));
    add_request(CMD_POP, '0, '0);

    // random phases, one capacity each
    foreach (phase_caps[p]) begin
      wait_idle();
      write_capacity(phase_caps[p]);
      repeat (PHASE_REQS) begin
        request_q.push_back(random_request());
        reqs_open++;
      end
    end

    wait_idle();
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (mismatch_cnt == 0 && cache_answers.size() == 0) begin
      $display("[lfu_cache] OK");
    end else begin
      $display("[lfu_cache] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("[lfu_cache] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/lfu_pkg.sv
sv/lfu_store.sv
sv/lfu_cache.sv
sim/tb_top.sv
